>>> rtl/nps_pkg.sv
// Shared types and constants for the nearest point search unit.
package nps_pkg;

  localparam int COORD_BITS = 20;
  localparam int POINT_BITS = 3 * COORD_BITS;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int DIST_BITS  = 42;
  localparam int INDEX_BITS = 8;
  localparam int PIPE_DEPTH = 4;
  localparam int DRAIN_W    = $clog2(PIPE_DEPTH);

  localparam logic [DIST_BITS-1:0] DIST_ONES    = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] CUTOFF_RESET = 42'd3298534883328;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                   action;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } item_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] nearest_index;
    logic [DIST_BITS-1:0]  distance_squared;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic load_query;
    logic report;
  } dp_cmd_t;

endpackage

>>> rtl/nearest_point_search_unit.sv
// Top level of the nearest point search unit: controller plus datapath.
//
//   Channel   Handshake                  Payload
//   input     start / busy               item   (nps_pkg::item_t)
//   result    result_valid (strobe)      result (nps_pkg::result_t)
//   config    cfg_we                     cfg_data (cutoff_squared)
//
// Clear and append leave busy low.
// A query holds busy while it scans the N stored points, one point store read
// per cycle, then drains the distance pipeline and reports.
// The result strobe follows in the first idle cycle.
// Reset (rst, synchronous) empties the table and restores the cutoff.
// The result is shown for one cycle only; the receiver cannot stall it.
module nearest_point_search_unit #(
  parameter int MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  nps_pkg::item_t                item,
  output logic                          result_valid,
  output nps_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [nps_pkg::DIST_BITS-1:0] cfg_data
);

  nps_pkg::dp_cmd_t              cmd;
  logic [$clog2(MAX_POINTS)-1:0] addr;

  nps_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(item.action),
    .busy  (busy),
    .cmd   (cmd),
    .addr  (addr)
  );

  nps_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .addr        (addr),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .result      (result),
    .result_valid(result_valid)
  );

`ifndef SYNTHESIS
  a_query_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.action == nps_pkg::ACT_QUERY) |=> busy)
    else $error("query item did not raise busy");

  a_other_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.action != nps_pkg::ACT_QUERY) |=> !busy)
    else $error("non-query item raised busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of a query");

  a_index_zero_not_found: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (result.nearest_index == '0))
    else $error("nonzero index on a miss");
`endif

endmodule

>>> rtl/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nps_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/nps_ctrl.sv
// Controller: point count, scan sequencing and the query state machine.
module nps_ctrl #(
  parameter int MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    action,
  output logic                          busy,
  output nps_pkg::dp_cmd_t              cmd,
  output logic [$clog2(MAX_POINTS)-1:0] addr
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t                      state, state_next;
  logic [CNT_W-1:0]            count, count_next;
  logic [IDX_W-1:0]            scan_addr, scan_addr_next;
  logic [nps_pkg::DRAIN_W-1:0] drain_cnt, drain_cnt_next;
  logic                        accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign addr   = (state == S_SCAN) ? scan_addr : count[IDX_W-1:0];

  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_addr_next = scan_addr;
    drain_cnt_next = drain_cnt;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            nps_pkg::ACT_CLEAR: begin
              count_next = '0;
            end
            nps_pkg::ACT_APPEND: begin
              // drop the point when the table is full
              if (count < CNT_W'(MAX_POINTS)) begin
                cmd.wr_en  = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            nps_pkg::ACT_QUERY: begin
              cmd.load_query = 1'b1;
              scan_addr_next = '0;
              drain_cnt_next = '0;
              state_next     = (count == '0) ? S_DRAIN : S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.rd_en      = 1'b1;
        scan_addr_next = scan_addr + IDX_W'(1);
        if (CNT_W'(scan_addr) + CNT_W'(1) == count) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let the last read work through the distance pipeline
        drain_cnt_next = drain_cnt + nps_pkg::DRAIN_W'(1);
        if (drain_cnt == nps_pkg::DRAIN_W'(nps_pkg::PIPE_DEPTH - 1)) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_addr <= '0;
      drain_cnt <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      scan_addr <= scan_addr_next;
      drain_cnt <= drain_cnt_next;
    end
  end

endmodule

>>> rtl/nps_datapath.sv
// Datapath: point store, distance pipeline, best tracker and result register.
module nps_datapath #(
  parameter int MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nps_pkg::dp_cmd_t              cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] addr,
  input  nps_pkg::item_t                item,
  input  logic                          cfg_we,
  input  logic [nps_pkg::DIST_BITS-1:0] cfg_data,
  output nps_pkg::result_t              result,
  output logic                          result_valid
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CB    = nps_pkg::COORD_BITS;
  localparam int MB    = nps_pkg::MAG_BITS;
  localparam int SB    = nps_pkg::SQ_BITS;
  localparam int DB    = nps_pkg::DIST_BITS;

  logic [DB-1:0]                 cutoff;
  logic signed [CB-1:0]          qx, qy, qz;
  logic [nps_pkg::POINT_BITS-1:0] rdata;
  logic signed [CB-1:0]          px, py, pz;
  logic signed [MB-1:0]          dx, dy, dz;
  logic [MB-1:0]                 ax_d, ay_d, az_d;
  logic [MB-1:0]                 ax, ay, az;
  logic [SB-1:0]                 sqx, sqy, sqz;
  logic [nps_pkg::SUM_BITS-1:0]  sum;
  logic [DB-1:0]                 dist_sq;
  logic [DB-1:0]                 best;
  logic [IDX_W-1:0]              best_idx;
  logic [IDX_W-1:0]              idx1, idx2, idx3, idx4;
  logic                          v1, v2, v3, v4;
  logic                          hit;

  nps_ram #(
    .WIDTH(nps_pkg::POINT_BITS),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(addr),
    .wdata({item.coord_z, item.coord_y, item.coord_x}),
    .re   (cmd.rd_en),
    .raddr(addr),
    .rdata(rdata)
  );

  assign px = rdata[CB-1:0];
  assign py = rdata[2*CB-1:CB];
  assign pz = rdata[3*CB-1:2*CB];

  assign dx   = MB'(px) - MB'(qx);
  assign dy   = MB'(py) - MB'(qy);
  assign dz   = MB'(pz) - MB'(qz);
  assign ax_d = dx[MB-1] ? MB'(-dx) : MB'(dx);
  assign ay_d = dy[MB-1] ? MB'(-dy) : MB'(dy);
  assign az_d = dz[MB-1] ? MB'(-dz) : MB'(dz);

  assign sum = nps_pkg::SUM_BITS'(sqx) + nps_pkg::SUM_BITS'(sqy) + nps_pkg::SUM_BITS'(sqz);
  assign hit = (best != nps_pkg::DIST_ONES) && (best <= cutoff);

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= nps_pkg::CUTOFF_RESET;
    end else if (cfg_we) begin
      cutoff <= cfg_data;
    end
  end

  // hold the query point for the whole scan
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qx <= item.coord_x;
      qy <= item.coord_y;
      qz <= item.coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= addr;
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    ax   <= ax_d;
    ay   <= ay_d;
    az   <= az_d;
    sqx  <= ax * ax;
    sqy  <= ay * ay;
    sqz  <= az * az;
    // clamp below all ones so a real distance never reads as an empty table
    if (sum >= nps_pkg::SUM_BITS'(nps_pkg::DIST_ONES)) begin
      dist_sq <= nps_pkg::DIST_ONES - DB'(1);
    end else begin
      dist_sq <= DB'(sum);
    end
  end

  // strict less-than keeps the earliest point on a tie
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      best     <= nps_pkg::DIST_ONES;
      best_idx <= '0;
    end else if (v4 && (dist_sq < best)) begin
      best     <= dist_sq;
      best_idx <= idx4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      result.found            <= hit;
      result.nearest_index    <= hit ? nps_pkg::INDEX_BITS'(best_idx) : '0;
      result.distance_squared <= best;
    end
  end

endmodule

>>> bench/nearest_point_search_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the nearest point search unit: mirrors the point table and checks query answers.
module nearest_point_search_unit_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  nps_pkg::item_t                item,
  input  logic                          result_valid,
  input  nps_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [nps_pkg::DIST_BITS-1:0] cfg_data,
  output int                            mismatches,
  output int                            awaiting,
  output int                            answers_checked,
  output int                            answers_found
);

  nps_pkg::item_t                point_table [TABLE_DEPTH];
  int                            point_total = 0;
  logic [nps_pkg::DIST_BITS-1:0] cutoff = nps_pkg::CUTOFF_RESET;
  nps_pkg::result_t              query_answers [$];
  int                            miss_count = 0;
  int                            checked = 0;
  int                            hits = 0;

  task automatic report_mismatch(input string what);
    if (miss_count < 40) begin
      $display("[%0t] mismatch on query answer %0d: %s", $time, checked, what);
    end
    miss_count++;
  endtask

  function automatic logic [nps_pkg::DIST_BITS-1:0] span_squared(input nps_pkg::item_t p,
                                                                 input nps_pkg::item_t q);
    longint dx;
    longint dy;
    longint dz;
    longint sum;
    dx = longint'($signed(p.coord_x)) - longint'($signed(q.coord_x));
    dy = longint'($signed(p.coord_y)) - longint'($signed(q.coord_y));
    dz = longint'($signed(p.coord_z)) - longint'($signed(q.coord_z));
    sum = dx * dx + dy * dy + dz * dz;
    // keep a real distance below the empty-table marker
    if (sum >= longint'(nps_pkg::DIST_ONES)) sum = longint'(nps_pkg::DIST_ONES) - 1;
    return sum[nps_pkg::DIST_BITS-1:0];
  endfunction

  function automatic nps_pkg::result_t nearest_from(input nps_pkg::item_t q);
    nps_pkg::result_t              r;
    logic [nps_pkg::DIST_BITS-1:0] best;
    logic [nps_pkg::DIST_BITS-1:0] d;
    int                            best_at;
    bit                            hit;
    best = nps_pkg::DIST_ONES;
    best_at = 0;
    hit = 1'b0;
    for (int i = 0; i < point_total; i++) begin
      d = span_squared(point_table[i], q);
      // strict compare keeps the earliest point on a tie
      if (d < best) begin
        best = d;
        best_at = i;
        hit = 1'b1;
      end
    end
    r.found = hit && (best <= cutoff);
    r.nearest_index = r.found ? best_at[nps_pkg::INDEX_BITS-1:0] : '0;
    r.distance_squared = best;
    return r;
  endfunction

  task automatic apply_item(input nps_pkg::item_t it);
    case (it.action)
      nps_pkg::ACT_CLEAR: begin
        point_total = 0;
      end
      nps_pkg::ACT_APPEND: begin
        if (point_total < TABLE_DEPTH) begin
          point_table[point_total] = it;
          point_total++;
        end
      end
      nps_pkg::ACT_QUERY: begin
        query_answers.push_back(nearest_from(it));
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    nps_pkg::result_t want;
    if (rst) begin
      point_total = 0;
      cutoff = nps_pkg::CUTOFF_RESET;
      query_answers.delete();
    end else begin
      if (result_valid) begin
        if (query_answers.size() == 0) begin
          report_mismatch("result with no query waiting");
        end else begin
          want = query_answers.pop_front();
          checked++;
          if (want.found) hits++;
          if (result.found !== want.found) begin
            report_mismatch($sformatf("found %0b, expected %0b", result.found, want.found));
          end
          if (result.nearest_index !== want.nearest_index) begin
            report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                      result.nearest_index, want.nearest_index));
          end
          if (result.distance_squared !== want.distance_squared) begin
            report_mismatch($sformatf("distance_squared %0d, expected %0d",
                                      result.distance_squared, want.distance_squared));
          end
        end
      end
      if (cfg_we) cutoff = cfg_data;
      if (start && !busy) apply_item(item);
    end
    mismatches <= miss_count;
    awaiting <= query_answers.size();
    answers_checked <= checked;
    answers_found <= hits;
  end

endmodule

>>> bench/nearest_point_search_unit_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the nearest point search unit.
module nearest_point_search_unit_tb;

  localparam int         TABLE_DEPTH = 256;
  localparam int         PHASE_ITEMS = 85;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam int CMIN = -(1 << (nps_pkg::COORD_BITS - 1));
  localparam int CMAX = (1 << (nps_pkg::COORD_BITS - 1)) - 1;

  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} spread_e;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  nps_pkg::item_t                item;
  logic                          result_valid;
  nps_pkg::result_t              result;
  logic                          cfg_we;
  logic [nps_pkg::DIST_BITS-1:0] cfg_data;

  int             mismatches;
  int             awaiting;
  int             answers_checked;
  int             answers_found;
  int             items_sent = 0;
  int             idle_pct = 0;
  nps_pkg::item_t placed [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nearest_point_search_unit #(.MAX_POINTS(TABLE_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  nearest_point_search_unit_checker #(.TABLE_DEPTH(TABLE_DEPTH)) chk (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item            (item),
    .result_valid    (result_valid),
    .result          (result),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .answers_checked (answers_checked),
    .answers_found   (answers_found)
  );

  initial begin
    #2000000;
    $display("Timeout: block stopped answering, %0d query answers outstanding", awaiting);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic nps_pkg::item_t make_item(input logic [1:0] act,
                                               input int x,
                                               input int y,
                                               input int z);
    nps_pkg::item_t it;
    it.action = act;
    it.coord_x = nps_pkg::COORD_BITS'(x);
    it.coord_y = nps_pkg::COORD_BITS'(y);
    it.coord_z = nps_pkg::COORD_BITS'(z);
    return it;
  endfunction

  function automatic int rand_coord(input spread_e sp);
    logic [31:0] r;
    r = $urandom();
    case (sp)
      SPREAD_NEAR: return int'($signed(r[12:0]));
      SPREAD_EDGE: begin
        case (r[31:29])
          3'd0:    return CMIN;
          3'd1:    return CMAX;
          3'd2:    return -1;
          3'd3:    return 0;
          3'd4:    return 1;
          default: return int'($signed(r[nps_pkg::COORD_BITS-1:0]));
        endcase
      end
      default: return int'($signed(r[nps_pkg::COORD_BITS-1:0]));
    endcase
  endfunction

  function automatic nps_pkg::item_t rand_point(input spread_e sp);
    return make_item(nps_pkg::ACT_APPEND, rand_coord(sp), rand_coord(sp), rand_coord(sp));
  endfunction

  // Mostly aim at stored points: exact hits, close misses, farther misses.
  function automatic nps_pkg::item_t near_query();
    nps_pkg::item_t q;
    int             span;
    if (placed.size() == 0 || $urandom_range(9) < 3) begin
      q = rand_point(spread_e'($urandom_range(2)));
    end else begin
      q = placed[$urandom_range(placed.size() - 1)];
      span = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 63 : 4095);
      q.coord_x = nps_pkg::COORD_BITS'(int'(q.coord_x) + (int'($urandom_range(2 * span)) - span));
      q.coord_y = nps_pkg::COORD_BITS'(int'(q.coord_y) + (int'($urandom_range(2 * span)) - span));
      q.coord_z = nps_pkg::COORD_BITS'(int'(q.coord_z) + (int'($urandom_range(2 * span)) - span));
    end
    q.action = nps_pkg::ACT_QUERY;
    return q;
  endfunction

  task automatic send(input nps_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (it.action == nps_pkg::ACT_CLEAR) begin
      placed.delete();
    end else if (it.action == nps_pkg::ACT_APPEND && placed.size() < TABLE_DEPTH) begin
      placed.push_back(it);
    end
  endtask

  // Drop start and wait until every query has been answered.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (awaiting != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cutoff(input logic [nps_pkg::DIST_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_sequence();
    int             n_app;
    int             n_q;
    spread_e        sp;
    nps_pkg::item_t it;
    logic [63:0]    noise;
    if ($urandom_range(99) < 15) begin
      noise = {$urandom(), $urandom()};
      send(noise[$bits(nps_pkg::item_t)-1:0]);
    end else begin
      if (placed.size() > 40 || $urandom_range(2) == 0) begin
        send(make_item(nps_pkg::ACT_CLEAR, rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL),
                       rand_coord(SPREAD_FULL)));
      end
      sp = spread_e'($urandom_range(2));
      n_app = ($urandom_range(4) == 0) ? $urandom_range(30, 13) : $urandom_range(12);
      repeat (n_app) begin
        it = rand_point(sp);
        // duplicates set up ties between stored points
        if (placed.size() != 0 && $urandom_range(9) == 0) begin
          it = placed[$urandom_range(placed.size() - 1)];
        end
        send(it);
      end
      n_q = $urandom_range(4, 1);
      repeat (n_q) send(near_query());
    end
  endtask

  task automatic run_phase(input int pct, input logic [nps_pkg::DIST_BITS-1:0] cut);
    int target;
    settle();
    write_cutoff(cut);
    idle_pct = pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) run_sequence();
  endtask

  // Fill the table, push extra points that must be dropped, then query.
  task automatic fill_table();
    nps_pkg::item_t spill;
    nps_pkg::item_t q;
    send(make_item(nps_pkg::ACT_CLEAR, 0, 0, 0));
    repeat (TABLE_DEPTH + 3) begin
      spill = rand_point(SPREAD_FULL);
      send(spill);
    end
    spill.action = nps_pkg::ACT_QUERY;
    send(spill);
    q = placed[TABLE_DEPTH - 1];
    q.action = nps_pkg::ACT_QUERY;
    send(q);
    q = placed[0];
    q.action = nps_pkg::ACT_QUERY;
    send(q);
    repeat (3) send(near_query());
  endtask

  initial begin : stimulus
    nps_pkg::item_t p;
    nps_pkg::item_t q;
    logic [63:0]    wide;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(make_item(nps_pkg::ACT_QUERY, CMAX, CMAX, CMAX));
    send(make_item(ACT_UNUSED, -1, -1, -1));
    send(make_item(nps_pkg::ACT_APPEND, CMIN, CMIN, CMIN));
    send(make_item(nps_pkg::ACT_APPEND, CMAX, CMAX, CMAX));
    send(make_item(nps_pkg::ACT_APPEND, 0, 0, 0));
    send(make_item(nps_pkg::ACT_APPEND, 0, 0, 0));
    send(make_item(nps_pkg::ACT_QUERY, CMAX, CMAX, CMAX));
    send(make_item(nps_pkg::ACT_QUERY, CMIN, CMIN, CMIN));
    send(make_item(nps_pkg::ACT_QUERY, 1, -1, 0));
    send(make_item(nps_pkg::ACT_CLEAR, CMAX, CMIN, -1));
    send(make_item(nps_pkg::ACT_QUERY, 0, 0, 0));
    send(make_item(nps_pkg::ACT_APPEND, CMIN, CMIN, CMIN));
    send(make_item(nps_pkg::ACT_QUERY, CMAX, CMAX, CMAX));
    send(make_item(nps_pkg::ACT_CLEAR, 0, 0, 0));

    // distance 25 from p to q: probe the cutoff boundary from both sides
    p = make_item(nps_pkg::ACT_APPEND, 1000, -2000, 3000);
    q = make_item(nps_pkg::ACT_QUERY, 1003, -1996, 3000);
    send(p);
    send(q);
    settle();
    write_cutoff(42'd25);
    send(q);
    settle();
    write_cutoff(42'd24);
    send(q);
    settle();
    write_cutoff('0);
    p.action = nps_pkg::ACT_QUERY;
    send(p);
    send(q);

    run_phase(0, nps_pkg::DIST_ONES);
    fill_table();
    run_phase(82, 42'($urandom_range(20000)));
    wide = {$urandom(), $urandom()};
    run_phase(0, wide[nps_pkg::DIST_BITS-1:0]);
    run_phase(18, '0);

    settle();
    repeat (16) @(posedge clk);
    $display("Sent %0d items: clears, appends to a full table and past it, ignored actions.",
             items_sent);
    $display("Checked %0d query answers (%0d within cutoff) over several cutoff settings.",
             answers_checked, answers_found);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nps_ctrl.sv
rtl/nps_datapath.sv
rtl/nearest_point_search_unit.sv
bench/nearest_point_search_unit_checker.sv
bench/nearest_point_search_unit_tb.sv
